/* rtl/core/tte_pkg.sv */
package tte_pkg;

    localparam int TIME_W      = 64;
    localparam int ID_W        = 4;
    localparam int REQ_W       = 2;

    // Slave tdata: req_type, timer_id, expiry_time, now_time, padded to bytes
    localparam int IN_FIELDS_W = REQ_W + ID_W + TIME_W + TIME_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    // Master tdata: fired_id, padded to a byte
    localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

    localparam int REQ_LSB     = 0;
    localparam int ID_LSB      = REQ_LSB + REQ_W;
    localparam int EXP_LSB     = ID_LSB + ID_W;
    localparam int NOW_LSB     = EXP_LSB + TIME_W;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [REQ_W-1:0]  t_req;

    localparam t_req REQ_ADD    = 2'd0;
    localparam t_req REQ_DELETE = 2'd1;
    localparam t_req REQ_TICK   = 2'd2;

endpackage

/* rtl/core/timer_table_expiry_scan.sv */
// Timer table with expiry scan.
// Slave stream (i_s_*) carries requests: add stores an expiry time for an
// entry and marks it live, delete drops the entry, tick carries the current
// time and removes every live entry whose expiry lies strictly below it.
// Master stream (o_m_*) carries one transfer per expired entry in ascending
// entry order; tlast marks the final one of a tick. A tick with nothing
// expired sends nothing.
// Add, delete and unused codes complete without leaving the idle state. A
// tick reads every expiry time out of the store (one read per cycle,
// registered read data), then walks the hit mask one entry per cycle,
// pausing while a hit waits on a master stall, until the last hit is sent.
// The single read port of the expiry store sets the scan length.
// Reset clears all live bits and the control state; the expiry store is
// not cleared, since an entry is only compared while live.
// A stalled master holds the output register and pauses the walk; the
// scan itself runs to completion. A finished result may wait in the
// output register while the next request is taken.
module timer_table_expiry_scan #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: req_type[1:0], timer_id[5:2], expiry_time[69:6],
    //        now_time[133:70], zero pad[135:134]
    input  logic [tte_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: fired_id[3:0], zero pad[7:4]; tlast: last_fired
    output logic [tte_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready
);
    import tte_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [TABLE_DEPTH-1:0] r_live;
    t_time                  r_now;
    logic [CW-1:0]          r_scan_cnt;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_cmp_last;
    logic [TABLE_DEPTH-1:0] r_mask;
    logic [CW-1:0]          r_hits;
    logic [IW-1:0]          r_walk;
    logic                   r_out_valid;
    t_id                    r_out_id;
    logic                   r_out_last;

    t_req                   in_req;
    t_id                    in_id;
    t_time                  in_expiry;
    t_time                  in_now;
    logic [IW+ID_W-1:0]     id_ext;
    logic [IW-1:0]          id_addr;
    logic                   id_ok;
    logic                   s_xfer;
    logic                   wr_en;
    logic [IW-1:0]          rd_addr;
    t_time                  rd_data;
    logic                   hit;
    logic [CW-1:0]          n_hits;
    logic                   out_free;
    logic [IW+ID_W-1:0]     walk_ext;

    // Unpack the request
    assign in_req    = i_s_tdata[REQ_LSB +: REQ_W];
    assign in_id     = i_s_tdata[ID_LSB +: ID_W];
    assign in_expiry = i_s_tdata[EXP_LSB +: TIME_W];
    assign in_now    = i_s_tdata[NOW_LSB +: TIME_W];

    assign id_ext  = {{IW{1'b0}}, in_id};
    assign id_addr = id_ext[IW-1:0];
    assign id_ok   = (32'(in_id) < TABLE_DEPTH);

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign wr_en      = s_xfer && (in_req == REQ_ADD) && id_ok;

    // Scan issues one read per cycle; the compare stage sees the data next cycle
    assign rd_addr = r_scan_cnt[IW-1:0];

    tte_expiry_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (id_addr),
        .i_wr_data (in_expiry),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Strictly below the tick time expires; equal does not
    assign hit    = r_cmp_vld && r_live[r_cmp_idx] && (rd_data < r_now);
    assign n_hits = r_hits + CW'(hit);

    assign out_free = !r_out_valid || i_m_tready;
    assign walk_ext = {{ID_W{1'b0}}, r_walk};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output once the master takes it; a new load below wins
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (s_xfer) begin
                        priority if (in_req == REQ_ADD) begin
                            if (id_ok) begin
                                r_live[id_addr] <= 1'b1;
                            end
                        end else if (in_req == REQ_DELETE) begin
                            if (id_ok) begin
                                r_live[id_addr] <= 1'b0;
                            end
                        end else if (in_req == REQ_TICK) begin
                            r_now      <= in_now;
                            r_scan_cnt <= '0;
                            r_hits     <= '0;
                            r_state    <= ST_SCAN;
                        end else begin
                            // unused request code: no effect
                        end
                    end
                end

                ST_SCAN: begin
                    // Advance the read address until every entry is issued
                    if (32'(r_scan_cnt) < TABLE_DEPTH) begin
                        r_cmp_vld  <= 1'b1;
                        r_cmp_idx  <= rd_addr;
                        r_cmp_last <= (32'(r_scan_cnt) == TABLE_DEPTH - 1);
                        r_scan_cnt <= r_scan_cnt + CW'(1);
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end

                    // Compare stage: remove expired entries, shift the hit in
                    if (r_cmp_vld) begin
                        r_mask <= {hit, r_mask[TABLE_DEPTH-1:1]};
                        r_hits <= n_hits;
                        if (hit) begin
                            r_live[r_cmp_idx] <= 1'b0;
                        end
                        if (r_cmp_last) begin
                            r_walk  <= '0;
                            r_state <= (n_hits == '0) ? ST_IDLE : ST_EMIT;
                        end
                    end
                end

                ST_EMIT: begin
                    // Hold the walk while a hit waits for a free output register
                    if (!r_mask[0] || out_free) begin
                        r_mask <= r_mask >> 1;
                        r_walk <= r_walk + IW'(1);
                        if (r_mask[0]) begin
                            r_out_valid <= 1'b1;
                            r_out_id    <= walk_ext[ID_W-1:0];
                            r_out_last  <= (r_hits == CW'(1));
                            r_hits      <= r_hits - CW'(1);
                            if (r_hits == CW'(1)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - ID_W){1'b0}}, r_out_id};
    assign o_m_tlast  = r_out_last;

endmodule

/* rtl/core/tte_expiry_mem.sv */
module tte_expiry_mem #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  tte_pkg::t_time                 i_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output tte_pkg::t_time                 o_rd_data
);
    import tte_pkg::*;

    t_time r_mem [TABLE_DEPTH];
    t_time r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* test/tb_timer_table_expiry_scan.sv */
module tb_timer_table_expiry_scan;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int    TABLE_DEPTH  = 16;
    // Request code 3 has no meaning; the block must drop it.
    localparam t_req  REQ_UNUSED   = 2'd3;
    // A tick reads the whole store, then walks the hit mask.
    localparam int    SCAN_LATENCY = 2 * TABLE_DEPTH + 1;
    // Cycles without any transfer before the run is declared hung.
    localparam int    STALL_LIMIT  = 1000;
    localparam int    RANDOM_ITEMS = 90;
    // Final stretch of the random traffic runs with no idling.
    localparam int    CALM_ITEMS   = 20;
    localparam t_time TIME_MAX     = '1;

    typedef struct packed {
        t_id  id;
        logic last;
    } t_expiration;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    // tdata: req_type, timer_id, expiry_time, now_time, zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // tdata: fired_id, zero pad; tlast: last_fired
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;

    // Shadow copy of the timer table
    bit          timer_live[TABLE_DEPTH];
    t_time       timer_deadline[TABLE_DEPTH];
    // Expirations predicted but not yet seen on the master side
    t_expiration due_expirations[$];

    int error_count = 0;
    int idle_cycles = 0;
    bit idle_enable = 1'b1;

    timer_table_expiry_scan #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Apply one accepted request to the shadow table; a tick queues every
    // live entry whose deadline lies strictly below the carried time.
    function automatic void update_timer_table(t_req req, t_id id, t_time deadline,
                                               t_time now);
        t_expiration fired[$];
        case (req)
            REQ_ADD: begin
                timer_live[id]     = 1'b1;
                timer_deadline[id] = deadline;
            end
            REQ_DELETE: begin
                timer_live[id] = 1'b0;
            end
            REQ_TICK: begin
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    if (timer_live[k] && timer_deadline[k] < now) begin
                        timer_live[k] = 1'b0;
                        fired.push_back('{id: t_id'(k), last: 1'b0});
                    end
                end
                if (fired.size() > 0)
                    fired[fired.size() - 1].last = 1'b1;
                foreach (fired[i])
                    due_expirations.push_back(fired[i]);
            end
            default: ;
        endcase
    endfunction

    // Predict on every accepted request and check every accepted result,
    // both sampled at the same edge the handshake completes on.
    always @(posedge i_clk) begin : result_check
        t_expiration want;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            update_timer_table(i_s_tdata[REQ_LSB +: REQ_W], i_s_tdata[ID_LSB +: ID_W],
                               i_s_tdata[EXP_LSB +: TIME_W], i_s_tdata[NOW_LSB +: TIME_W]);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_expirations.size() == 0) begin
                report_mismatch($sformatf("unexpected expiry of entry %0d",
                                          o_m_tdata[ID_W-1:0]));
            end else begin
                want = due_expirations.pop_front();
                if (o_m_tdata[ID_W-1:0] !== want.id)
                    report_mismatch($sformatf("fired_id %0d, expected %0d",
                                              o_m_tdata[ID_W-1:0], want.id));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("last_fired %0b on entry %0d, expected %0b",
                                              o_m_tlast, want.id, want.last));
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("HANG: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: drop ready for random-length bursts while idling is on.
    always begin
        @(posedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    function automatic t_time rand_time();
        return {$urandom(), $urandom()};
    endfunction

    // Send one request and hold it until accepted; valid stays high for a
    // back-to-back follower unless a random gap is taken first.
    task automatic send_request(t_req req, t_id id, t_time deadline, t_time now);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, now, deadline, id, req};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Unused fields of each request carry random values.
    task automatic add_timer(t_id id, t_time deadline);
        send_request(REQ_ADD, id, deadline, rand_time());
    endtask

    task automatic delete_timer(t_id id);
        send_request(REQ_DELETE, id, rand_time(), rand_time());
    endtask

    task automatic tick(t_time now);
        send_request(REQ_TICK, t_id'($urandom_range(0, 15)), rand_time(), now);
    endtask

    // Hold the sender until every predicted expiration has been seen.
    task automatic wait_all_fired();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_expirations.size() != 0) @(posedge i_clk);
    endtask

    // Ticks on an empty table must produce nothing.
    task automatic test_empty_tick();
        tick(TIME_MAX);
        tick('0);
    endtask

    // Deadlines at both ends of the time range, equal times that must not
    // fire, and a delete of a live entry.
    task automatic test_time_extremes();
        add_timer(4'd0, '0);
        add_timer(4'd15, TIME_MAX - 1);
        add_timer(4'd7, TIME_MAX);
        tick('0);
        tick(t_time'(1));
        tick(TIME_MAX);
        delete_timer(4'd7);
        tick(TIME_MAX);
        wait_all_fired();
    endtask

    // Re-adding a live entry replaces its deadline; deleting a dead entry
    // does nothing.
    task automatic test_overwrite_delete();
        add_timer(4'd3, t_time'(100));
        add_timer(4'd3, t_time'(10));
        delete_timer(4'd5);
        tick(t_time'(60));
        add_timer(4'd9, t_time'(5));
        delete_timer(4'd9);
        tick(TIME_MAX);
    endtask

    // The unused request code must leave the table untouched.
    task automatic test_unused_request();
        send_request(REQ_UNUSED, 4'd2, '0, TIME_MAX);
        tick(TIME_MAX);
    endtask

    // Random traffic around a moving time window, so ticks expire part of
    // the table; now and then fill the whole table and expire it at once.
    task automatic test_random_traffic();
        int    sent;
        int    pick;
        t_time epoch;
        sent  = 0;
        epoch = rand_time();
        while (sent < RANDOM_ITEMS) begin
            idle_enable = (sent < RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 19) == 0)
                epoch = rand_time();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_timer(t_id'($urandom_range(0, 15)), epoch + $urandom_range(0, 255));
                sent++;
            end else if (pick < 55) begin
                delete_timer(t_id'($urandom_range(0, 15)));
                sent++;
            end else if (pick < 85) begin
                if ($urandom_range(0, 7) == 0)
                    tick(rand_time());
                else
                    tick(epoch + $urandom_range(0, 300));
                sent++;
            end else if (pick < 92) begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                    add_timer(t_id'(k), epoch + $urandom_range(0, 255));
                tick(epoch + 256);
                if ($urandom_range(0, 1) == 0)
                    wait_all_fired();
                sent += TABLE_DEPTH + 1;
            end else begin
                send_request(REQ_UNUSED, t_id'($urandom_range(0, 15)), rand_time(),
                             rand_time());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tick();
        test_time_extremes();
        test_overwrite_delete();
        test_unused_request();
        test_random_traffic();

        // Drain, then give a scan that fires nothing time to finish.
        wait_all_fired();
        repeat (SCAN_LATENCY + 16) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* timer_table_expiry_scan.f */
rtl/core/tte_pkg.sv
rtl/core/tte_expiry_mem.sv
rtl/core/timer_table_expiry_scan.sv
test/tb_timer_table_expiry_scan.sv
